// File: design/pcat_pkg.sv
package pcat_pkg;

  localparam int unsigned MaxChannels = 4;
  localparam int unsigned ModeW       = 3;
  localparam int unsigned ShiftW      = 5;
  localparam int unsigned ResW        = 2;
  localparam int unsigned OvfW        = 8;
  localparam int unsigned ValW        = 16;
  localparam int unsigned StampW      = OvfW + ValW;
  localparam int unsigned ReloadW     = 10;
  localparam int unsigned PwmMaxW     = 11;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 20;

  localparam logic [ValW-1:0]    DurMax     = 16'hFFFF;
  localparam logic [PwmMaxW-1:0] PwmMax8    = 11'd256;
  localparam logic [PwmMaxW-1:0] PwmMax7    = 11'd128;
  localparam logic [PwmMaxW-1:0] PwmMax6    = 11'd64;
  localparam logic [PwmMaxW-1:0] PwmMax10   = 11'd1024;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EVENT = 2'd1,
    OP_DUTY  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_UNUSED  = 3'd0,
    MODE_CAPTURE = 3'd1,
    MODE_PWM     = 3'd2,
    MODE_TIMER   = 3'd3,
    MODE_PULSE   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    RES_8  = 2'd0,
    RES_7  = 2'd1,
    RES_6  = 2'd2,
    RES_10 = 2'd3
  } res_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODES   = 3'd0,
    REG_ONESHOT = 3'd1,
    REG_SHIFT   = 3'd2,
    REG_RES     = 3'd3,
    REG_PERIOD0 = 3'd4,
    REG_PERIOD1 = 3'd5,
    REG_PERIOD2 = 3'd6,
    REG_PERIOD3 = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [1:0]      channel;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               notify;
    logic [1:0]         channel_out;
    logic [ValW-1:0]    duration;
    logic [ValW-1:0]    next_compare;
    logic [ReloadW-1:0] reload_value;
    logic               disarmed;
  } out_item_t;

  typedef struct packed {
    logic                present;
    logic [ModeW-1:0]    mode;
    logic                oneshot;
    logic [ShiftW-1:0]   shift;
    logic [ResW-1:0]     res;
    logic [ValW-1:0]     period;
    logic [OvfW-1:0]     ovf;
    logic [StampW-1:0]   last;
    logic [ValW-1:0]     acc;
    logic                stopped;
  } chan_view_t;

  typedef struct packed {
    logic                tick;
    logic                wr;
    logic [1:0]          ch;
    logic                stamp_we;
    logic [StampW-1:0]   stamp;
    logic                acc_we;
    logic [ValW-1:0]     acc;
    logic                stop_set;
  } chan_upd_t;

  function automatic logic [PwmMaxW-1:0] pwm_max(input logic [ResW-1:0] r);
    logic [PwmMaxW-1:0] m;
    case (res_e'(r))
      RES_8:   m = PwmMax8;
      RES_7:   m = PwmMax7;
      RES_6:   m = PwmMax6;
      RES_10:  m = PwmMax10;
      default: m = PwmMax8;
    endcase
    return m;
  endfunction

endpackage

// File: design/pcat_state.sv
module pcat_state #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcat_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pcat_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic [1:0]                           sel_ch_i,
  output pcat_pkg::chan_view_t                 view_o,
  input  pcat_pkg::chan_upd_t                  upd_i
);
  import pcat_pkg::*;

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [MaxChannels*ModeW-1:0]  modes_q, modes_d;
  logic [MaxChannels-1:0]        oneshot_q, oneshot_d;
  logic [MaxChannels*ShiftW-1:0] shift_q, shift_d;
  logic [MaxChannels*ResW-1:0]   res_q, res_d;

  logic [ValW-1:0]   period_q  [CHANNELS];
  logic [ValW-1:0]   period_d  [CHANNELS];
  logic [OvfW-1:0]   ovf_q     [CHANNELS];
  logic [OvfW-1:0]   ovf_d     [CHANNELS];
  logic [StampW-1:0] last_q    [CHANNELS];
  logic [StampW-1:0] last_d    [CHANNELS];
  logic [ValW-1:0]   acc_q     [CHANNELS];
  logic [ValW-1:0]   acc_d     [CHANNELS];
  logic [CHANNELS-1:0] stopped_q, stopped_d;

  logic [ChW-1:0] sel;
  logic [CfgIdxW-1:0] per_idx;

  assign sel     = sel_ch_i[ChW-1:0];
  assign per_idx = cfg_index_i - REG_PERIOD0;

  always_comb begin
    logic [ModeW-1:0] new_mode;
    modes_d   = modes_q;
    oneshot_d = oneshot_q;
    shift_d   = shift_q;
    res_d     = res_q;
    period_d  = period_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    acc_d     = acc_q;
    stopped_d = stopped_q;
    new_mode  = '0;
    if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_MODES: begin
          modes_d = cfg_data_i[MaxChannels*ModeW-1:0];
          for (int c = 0; c < CHANNELS; c++) begin
            new_mode = cfg_data_i[ModeW*c +: ModeW];
            if (new_mode != modes_q[ModeW*c +: ModeW] || stopped_q[c]) begin
              stopped_d[c] = 1'b0;
              if (new_mode == MODE_CAPTURE) begin
                ovf_d[c]  = '0;
                last_d[c] = '0;
              end else if (new_mode == MODE_TIMER || new_mode == MODE_PULSE) begin
                acc_d[c] = period_q[c];
              end
            end
          end
        end
        REG_ONESHOT: oneshot_d = cfg_data_i[MaxChannels-1:0];
        REG_SHIFT:   shift_d   = cfg_data_i[MaxChannels*ShiftW-1:0];
        REG_RES:     res_d     = cfg_data_i[MaxChannels*ResW-1:0];
        REG_PERIOD0, REG_PERIOD1, REG_PERIOD2, REG_PERIOD3: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (per_idx == CfgIdxW'(c)) begin
              period_d[c] = cfg_data_i[ValW-1:0];
              acc_d[c]    = cfg_data_i[ValW-1:0];
            end
          end
        end
        default: ;
      endcase
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (upd_i.tick) begin
          ovf_d[c] = ovf_q[c] + OvfW'(1);
        end
        if (upd_i.wr && upd_i.ch == 2'(c)) begin
          if (upd_i.stamp_we) begin
            last_d[c] = upd_i.stamp;
          end
          if (upd_i.acc_we) begin
            acc_d[c] = upd_i.acc;
          end
          if (upd_i.stop_set) begin
            stopped_d[c] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q   <= '0;
      oneshot_q <= '0;
      shift_q   <= '0;
      res_q     <= '0;
      stopped_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        period_q[c] <= '0;
        ovf_q[c]    <= '0;
        last_q[c]   <= '0;
        acc_q[c]    <= '0;
      end
    end else begin
      modes_q   <= modes_d;
      oneshot_q <= oneshot_d;
      shift_q   <= shift_d;
      res_q     <= res_d;
      stopped_q <= stopped_d;
      period_q  <= period_d;
      ovf_q     <= ovf_d;
      last_q    <= last_d;
      acc_q     <= acc_d;
    end
  end

  always_comb begin
    view_o         = '0;
    view_o.present = (32'(sel_ch_i) < CHANNELS);
    view_o.mode    = modes_q[ModeW*sel_ch_i +: ModeW];
    view_o.oneshot = oneshot_q[sel_ch_i];
    view_o.shift   = shift_q[ShiftW*sel_ch_i +: ShiftW];
    view_o.res     = res_q[ResW*sel_ch_i +: ResW];
    if (view_o.present) begin
      view_o.period  = period_q[sel];
      view_o.ovf     = ovf_q[sel];
      view_o.last    = last_q[sel];
      view_o.acc     = acc_q[sel];
      view_o.stopped = stopped_q[sel];
    end
  end

endmodule

// File: design/pcat_engine.sv
module pcat_engine (
  input  logic                 go_i,
  input  pcat_pkg::in_item_t   item_i,
  input  pcat_pkg::chan_view_t view_i,
  output pcat_pkg::out_item_t  res_o,
  output pcat_pkg::chan_upd_t  upd_o
);
  import pcat_pkg::*;

  logic [StampW-1:0]  stamp;
  logic [StampW-1:0]  diff;
  logic [StampW-1:0]  shifted;
  logic [ValW-1:0]    acc_next;
  logic [PwmMaxW-1:0] mx;
  logic [PwmMaxW-1:0] high;
  logic [PwmMaxW-1:0] reload_full;

  assign stamp       = {view_i.ovf, item_i.value};
  assign diff        = stamp - view_i.last;
  assign shifted     = diff >> view_i.shift;
  assign acc_next    = view_i.acc + view_i.period;
  assign mx          = pwm_max(view_i.res);
  assign high        = (item_i.value >= ValW'(mx)) ? (mx - PwmMaxW'(1))
                                                   : item_i.value[PwmMaxW-1:0];
  assign reload_full = mx - high;

  always_comb begin
    res_o    = '0;
    upd_o    = '0;
    upd_o.ch = item_i.channel;
    case (op_e'(item_i.operation))
      OP_TICK: begin
        upd_o.tick = go_i;
      end
      OP_EVENT: begin
        res_o.channel_out = item_i.channel;
        if (view_i.present && !view_i.stopped) begin
          case (mode_e'(view_i.mode))
            MODE_CAPTURE: begin
              res_o.notify   = 1'b1;
              res_o.duration = (|shifted[StampW-1:ValW]) ? DurMax : shifted[ValW-1:0];
              upd_o.wr       = go_i;
              upd_o.stamp_we = 1'b1;
              upd_o.stamp    = stamp;
              if (view_i.oneshot) begin
                upd_o.stop_set = 1'b1;
                res_o.disarmed = 1'b1;
              end
            end
            MODE_PWM: begin
              res_o.notify = 1'b1;
            end
            MODE_TIMER, MODE_PULSE: begin
              res_o.next_compare = acc_next;
              res_o.notify       = (view_i.mode == MODE_TIMER);
              upd_o.wr           = go_i;
              upd_o.acc_we       = 1'b1;
              upd_o.acc          = acc_next;
            end
            default: ;
          endcase
        end
      end
      OP_DUTY: begin
        res_o.channel_out = item_i.channel;
        if (view_i.present) begin
          res_o.reload_value = reload_full[ReloadW-1:0];
        end
      end
      default: begin
        res_o.channel_out = item_i.channel;
      end
    endcase
  end

endmodule

// File: design/pca_capture_timer_pwm_channels.sv
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i/in_ready_o   | operation, channel, value
// out     | output    | out_valid_o/out_ready_i | notify .. disarmed
// cfg     | input     | cfg_valid_i/cfg_ready_o | register index, write data
//
// One beat in, one beat out; a new beat is taken every cycle when out is drained.
// Each beat passes the input register, then the channel read-modify-write
// into the result register. The channel update is one short add/shift per beat.
// Reset clears the valid flags, configuration and channel state; cfg_ready_o is
// always high.
// With out stalled, one further beat is held in the input register.
module pca_capture_timer_pwm_channels #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pcat_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pcat_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcat_pkg::CfgDataW-1:0] cfg_data_i
);
  import pcat_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  in_item_t   s1_q, s1_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic       out_free;
  logic       s1_adv;
  logic       in_fire;
  chan_view_t view;
  chan_upd_t  upd;
  out_item_t  res;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  pcat_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sel_ch_i    (s1_q.channel),
    .view_o      (view),
    .upd_i       (upd)
  );

  pcat_engine u_engine (
    .go_i   (s1_adv),
    .item_i (s1_q),
    .view_i (view),
    .res_o  (res),
    .upd_o  (upd)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_d        = s1_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
      s1_d       = in_data_i;
    end
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with a free stage");

  a_disarm_notify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disarmed |-> out_data_o.notify && out_data_o.next_compare == '0)
    else $error("disarm reported outside a capture");

  a_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_q.operation == OP_TICK |=> out_valid_o && out_data_o == '0)
    else $error("overflow tick gave a non-zero result");
`endif

endmodule
